FILE: rtl/assert_macros.svh
// Assertion macros shared by the modular exponentiation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define MEXP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("modular exponentiation assertion failed");

// Checked at every rising edge, reset included.
`define MEXP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("modular exponentiation assertion failed");

`endif

FILE: rtl/mexp_pkg.sv
// Package with constants, types and control codes of the modular exponentiation unit.
package mexp_pkg;

  localparam int EXP_BITS = 31;
  localparam int MOD_BITS = 31;
  localparam int DATA_W   = 31;
  localparam int ADDR_W   = 3;
  localparam int YW       = (MOD_BITS > DATA_W) ? MOD_BITS : DATA_W;
  localparam int CNT_W    = $clog2(YW);

  typedef logic [MOD_BITS-1:0] mod_t;
  typedef logic [MOD_BITS+1:0] sum_t;
  typedef logic [EXP_BITS-1:0] exp_t;
  typedef logic [DATA_W-1:0]   data_t;
  typedef logic [YW-1:0]       yword_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [31:0]         word_t;
  typedef logic [ADDR_W-3:0]   reg_idx_t;

  localparam mod_t     MODULUS_RESET = mod_t'(32'd1000000007);
  localparam cnt_t     CNT_LAST      = cnt_t'(YW - 1);
  localparam reg_idx_t REG_MODULUS   = reg_idx_t'(0);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_MUL,
    ST_WB,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic accept;
    logic step;
    logic red;
    logic wb;
    logic take_acc;
    logic load_out;
  } ctrl_t;

endpackage

FILE: rtl/modular_exponentiation_unit.sv
// Top level of the modular exponentiation unit: register port, datapath, result register.
//
//   channel  direction  handshake            payload
//   in       request    in_valid / in_stall  in_base, in_exponent
//   out      result     out_valid/out_stall  out_power
//   cfg      register   psel/penable/pready  paddr, pwdata, prdata
//
// One request runs a reduction pass of the base, then one multiply pass per significant exponent
// bit (none for a zero exponent); each pass covers YW multiplier bits (YW is 31 here) and ends
// in a write-back. The bit-serial multiplier lanes take one multiplier bit per cycle.
// A modulus below two skips the passes and answers 0. Reset is synchronous and restores the
// modulus; a waiting result holds under out_stall, and a later result waits, busy, in ST_FIN.
`include "assert_macros.svh"

module modular_exponentiation_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mexp_pkg::DATA_W-1:0]     in_base,
  input  logic [mexp_pkg::DATA_W-1:0]     in_exponent,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mexp_pkg::DATA_W-1:0]     out_power,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mexp_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  mexp_pkg::ctrl_t  ctrl;
  mexp_pkg::mod_t   modulus_r;
  mexp_pkg::mod_t   b_r;
  mexp_pkg::mod_t   acc_r;
  mexp_pkg::mod_t   lane_a_r;
  mexp_pkg::mod_t   lane_b_r;
  mexp_pkg::mod_t   lane_b_x;
  mexp_pkg::yword_t y_r;
  mexp_pkg::data_t  out_power_r;
  logic             out_valid_r;
  logic             zero_r;
  logic             m_small;
  logic             out_free;
  logic             cfg_wr;
  logic             lane_clr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready &&
                   (paddr[mexp_pkg::ADDR_W-1:2] == mexp_pkg::REG_MODULUS);
  assign prdata  = (paddr[mexp_pkg::ADDR_W-1:2] == mexp_pkg::REG_MODULUS) ?
                   mexp_pkg::word_t'(modulus_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mexp_pkg::MODULUS_RESET;
    end else if (cfg_wr) begin
      modulus_r <= mexp_pkg::mod_t'(pwdata);
    end
  end

  assign m_small  = (modulus_r < mexp_pkg::mod_t'(2));
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = ctrl.busy;

  mexp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_exponent (in_exponent),
    .m_small     (m_small),
    .out_free    (out_free),
    .ctrl        (ctrl)
  );

  assign lane_clr = ctrl.accept || ctrl.wb;
  assign lane_b_x = ctrl.red ? mexp_pkg::mod_t'(1) : b_r;

  mexp_mmul_lane u_lane_a (
    .clk  (clk),
    .clr  (lane_clr),
    .step (ctrl.step),
    .x    (acc_r),
    .ybit (y_r[mexp_pkg::YW-1]),
    .m    (modulus_r),
    .r    (lane_a_r)
  );

  mexp_mmul_lane u_lane_b (
    .clk  (clk),
    .clr  (lane_clr),
    .step (ctrl.step),
    .x    (lane_b_x),
    .ybit (y_r[mexp_pkg::YW-1]),
    .m    (modulus_r),
    .r    (lane_b_r)
  );

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      y_r    <= mexp_pkg::yword_t'(in_base);
      acc_r  <= mexp_pkg::mod_t'(1);
      zero_r <= m_small;
    end else begin
      if (ctrl.step) begin
        y_r <= y_r << 1;
      end else if (ctrl.wb) begin
        y_r <= mexp_pkg::yword_t'(lane_b_r);
      end
      if (ctrl.take_acc) begin
        acc_r <= lane_a_r;
      end
    end
    if (ctrl.wb) begin
      b_r <= lane_b_r;
    end
    if (ctrl.load_out) begin
      out_power_r <= zero_r ? '0 : mexp_pkg::data_t'(acc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_power = out_power_r;

  `MEXP_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall)
  `MEXP_ASSERT(a_no_overwrite, clk, rst_n, ctrl.load_out |-> out_free)
  `MEXP_ASSERT(a_square_reduced, clk, rst_n, ctrl.wb |-> (lane_b_r < modulus_r))
  `MEXP_ASSERT(a_result_reduced, clk, rst_n,
    out_valid_r && !m_small |->
    ({2'b00, out_power_r} < {{(mexp_pkg::DATA_W-mexp_pkg::MOD_BITS+2){1'b0}}, modulus_r}))

endmodule

FILE: rtl/mexp_mmul_lane.sv
// Bit-serial interleaved modular multiplier lane, one multiplier bit per cycle while step is high.
module mexp_mmul_lane (
  input  logic            clk,
  input  logic            clr,
  input  logic            step,
  input  mexp_pkg::mod_t  x,
  input  logic            ybit,
  input  mexp_pkg::mod_t  m,
  output mexp_pkg::mod_t  r
);

  mexp_pkg::mod_t r_r;
  mexp_pkg::mod_t r_nxt;
  mexp_pkg::sum_t s;
  mexp_pkg::sum_t t1;
  mexp_pkg::sum_t mm;

  always_comb begin
    mm = mexp_pkg::sum_t'(m);
    s  = (mexp_pkg::sum_t'(r_r) << 1) + (ybit ? mexp_pkg::sum_t'(x) : '0);
    t1 = (s >= mm) ? s - mm : s;
    if (t1 >= mm) begin
      r_nxt = mexp_pkg::mod_t'(t1 - mm);
    end else begin
      r_nxt = mexp_pkg::mod_t'(t1);
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      r_r <= '0;
    end else if (step) begin
      r_r <= r_nxt;
    end
  end

  assign r = r_r;

endmodule

FILE: rtl/mexp_ctrl.sv
// Sequencer for the reduction, multiply and write-back phases, with the exponent shift register.
module mexp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  mexp_pkg::data_t in_exponent,
  input  logic            m_small,
  input  logic            out_free,
  output mexp_pkg::ctrl_t ctrl
);

  mexp_pkg::state_t state_r;
  mexp_pkg::state_t state_nxt;
  mexp_pkg::cnt_t   cnt_r;
  mexp_pkg::cnt_t   cnt_nxt;
  mexp_pkg::exp_t   e_r;
  mexp_pkg::exp_t   e_nxt;
  mexp_pkg::exp_t   e_adv;
  logic             mul_phase_r;
  logic             mul_phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::ST_IDLE;
      cnt_r       <= '0;
      e_r         <= '0;
      mul_phase_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      e_r         <= e_nxt;
      mul_phase_r <= mul_phase_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    e_nxt         = e_r;
    mul_phase_nxt = mul_phase_r;
    e_adv         = mul_phase_r ? (e_r >> 1) : e_r;
    ctrl          = '0;
    case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctrl.accept   = 1'b1;
          cnt_nxt       = '0;
          e_nxt         = mexp_pkg::exp_t'(in_exponent);
          mul_phase_nxt = 1'b0;
          state_nxt     = m_small ? mexp_pkg::ST_FIN : mexp_pkg::ST_RED;
        end
      end
      mexp_pkg::ST_RED, mexp_pkg::ST_MUL: begin
        ctrl.busy = 1'b1;
        ctrl.step = 1'b1;
        ctrl.red  = (state_r == mexp_pkg::ST_RED);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == mexp_pkg::CNT_LAST) begin
          state_nxt = mexp_pkg::ST_WB;
        end
      end
      mexp_pkg::ST_WB: begin
        ctrl.busy     = 1'b1;
        ctrl.wb       = 1'b1;
        ctrl.take_acc = mul_phase_r && e_r[0];
        e_nxt         = e_adv;
        mul_phase_nxt = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = (e_adv == '0) ? mexp_pkg::ST_FIN : mexp_pkg::ST_MUL;
      end
      mexp_pkg::ST_FIN: begin
        ctrl.busy = 1'b1;
        if (out_free) begin
          ctrl.load_out = 1'b1;
          state_nxt     = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: dv/tb_top.sv
// Testbench for the modular exponentiation unit: directed and random requests checked against a power predictor.
`timescale 1ns / 100ps

module tb_top;
  import mexp_pkg::*;

  localparam reg_idx_t REG_SPARE = reg_idx_t'(1);
  localparam data_t    FIELD_MAX = '1;
  localparam int       DRAIN_CYCLES = 1100;

  class power_checker;
    mod_t        modulus;
    data_t       power_q[$];
    int unsigned failures;

    function new();
      modulus  = MODULUS_RESET;
      failures = 0;
    endfunction

    function void set_modulus(word_t value);
      modulus = mod_t'(value);
    endfunction

    function data_t expected_power(data_t base, exp_t exponent);
      longint unsigned m;
      longint unsigned acc;
      longint unsigned sq;
      m = modulus;
      if (m < 2) begin
        return '0;
      end
      sq  = base % m;
      acc = 1;
      for (int i = 0; i < EXP_BITS; i++) begin
        if (exponent[i]) begin
          acc = (acc * sq) % m;
        end
        sq = (sq * sq) % m;
      end
      return data_t'(acc);
    endfunction

    function void note_request(data_t base, exp_t exponent);
      power_q.push_back(expected_power(base, exponent));
    endfunction

    function void log_mismatch(string what, longint unsigned want, longint unsigned got);
      failures++;
      if (failures <= 10) begin
        $display("%s mismatch: expected %0d, got %0d", what, want, got);
      end
    endfunction

    function void check_power(data_t got);
      data_t want;
      if (power_q.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("power %0d arrived with no request outstanding", got);
        end
      end else begin
        want = power_q.pop_front();
        if (want != got) begin
          log_mismatch("power", want, got);
        end
      end
    endfunction

    function int pending();
      return power_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  data_t               in_base = '0;
  data_t               in_exponent = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  data_t               out_power;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  power_checker sb = new();
  bit           tx_idle_en = 1'b1;
  bit           rx_idle_en = 1'b1;
  int           hold_cycles = 0;

  always #5 clk = ~clk;

  modular_exponentiation_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_power   (out_power),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  function automatic logic [ADDR_W-1:0] reg_addr(reg_idx_t idx);
    return {idx, 2'b00};
  endfunction

  task automatic reg_write(reg_idx_t idx, word_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(idx);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_MODULUS) begin
      sb.set_modulus(value);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_modulus_readback();
    word_t got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(REG_MODULUS);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got != word_t'(sb.modulus)) begin
      sb.log_mismatch("modulus readback", sb.modulus, got);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_request(data_t base, exp_t exponent);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_base     <= base;
    in_exponent <= exponent;
    do @(posedge clk); while (in_stall);
    sb.note_request(base, exponent);
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    data_t base;
    exp_t  exponent;
    int    width;
    repeat (count) begin
      case ($urandom_range(0, 7))
        0: base = '0;
        1: base = FIELD_MAX;
        2: base = data_t'(sb.modulus) + data_t'($urandom_range(0, 3));
        3: base = data_t'(sb.modulus) - 1'b1;
        default: base = data_t'($urandom());
      endcase
      case ($urandom_range(0, 7))
        0: exponent = '0;
        1, 2: exponent = exp_t'($urandom());
        default: begin
          width    = $urandom_range(1, 8);
          exponent = exp_t'($urandom_range(0, (1 << width) - 1));
        end
      endcase
      send_request(base, exponent);
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_power(out_power);
      end
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    word_t mod_plan[9];
    mod_plan = '{32'd2, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd13,
                 word_t'($urandom_range(3, 1000)), $urandom(), $urandom(),
                 32'd1000000007};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    check_modulus_readback();
    send_request('0, '0);
    send_request(FIELD_MAX, '0);
    send_request('0, FIELD_MAX);
    send_request(FIELD_MAX, FIELD_MAX);
    send_request(data_t'(1), FIELD_MAX);
    send_request(data_t'(2), exp_t'(30));
    send_request(data_t'(MODULUS_RESET), exp_t'(5));
    send_request(data_t'(MODULUS_RESET) + 1'b1, exp_t'(3));
    send_request(data_t'(3), exp_t'(31'h4000_0000));
    send_request(data_t'(31'h5555_5555), exp_t'(31'h2AAA_AAAA));
    send_request(data_t'(31'h2AAA_AAAA), exp_t'(31'h5555_5555));
    in_valid <= 1'b0;
    wait_idle();

    reg_write(REG_SPARE, 32'h0000_0003);
    check_modulus_readback();
    send_request(data_t'(12345), exp_t'(6789));
    in_valid <= 1'b0;
    wait_idle();

    foreach (mod_plan[i]) begin
      if (i == 8) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      reg_write(REG_MODULUS, mod_plan[i]);
      check_modulus_readback();
      if (i == 4) begin
        hold_cycles = 3000;
      end
      send_request(FIELD_MAX, '0);
      send_request(FIELD_MAX, FIELD_MAX);
      send_random(42);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule
